// ===== design/per_cpu_page_free_list_allocator_defines.svh =====
// assertion macros for the per-cpu page free list allocator
// no dependencies; included by files that check their own logic
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define PCPFL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// antecedent implies consequent in the next cycle
`define PCPFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define PCPFL_ASSERT_SAME(label, clk, rst, ante, cons)
`define PCPFL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/pcpfl_pkg.sv =====
// shared types, constants and helpers of the per-cpu page free list allocator
// no dependencies
package pcpfl_pkg;

   localparam int CPU_COUNT  = 8;
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_COUNT = 32768;

   localparam int ADDR_W   = 40;
   localparam int CPU_IN_W = 3;
   localparam int CPU_W    = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
   localparam int IDX_W    = $clog2(PAGE_COUNT);
   localparam int LINK_W   = IDX_W + 1;
   // page number of the rounded-up base, with room for the carry
   localparam int FIRST_W  = ADDR_W - PAGE_SHIFT + 1;
   localparam int DIFF_W   = FIRST_W + 1;

   // request commands
   localparam logic CMD_FREE  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_FREE = 2'd1;
   localparam logic [1:0] ST_NO_PAGE  = 2'd2;

   // register indexes
   localparam logic CSR_BASE_ADDR = 1'b0;
   localparam logic CSR_TOP_ADDR  = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic load;   // capture request word
      logic eval;   // address check and list selection
      logic exec;   // push, or pop read of the link memory
      logic link;   // finish the pop with the link read back
   } ctl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic alloc_hit;   // allocate found a non-empty list
   } dp_status_type;

   // cpu number reduced modulo the cpu count
   function automatic logic [CPU_W-1:0] cpu_wrap(input logic [CPU_IN_W-1:0] v);
      logic [6:0] t;
      t = 7'(v);
      for (int i = 0; i < 8; i++) begin
         if (t >= 7'(CPU_COUNT)) begin
            t = t - 7'(CPU_COUNT);
         end
      end
      return t[CPU_W-1:0];
   endfunction

endpackage

// ===== design/pcpfl_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module pcpfl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pcpfl_ctrl.sv =====
// request sequencer of the per-cpu page free list allocator
// depends on pcpfl_pkg
module pcpfl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  pcpfl_pkg::dp_status_type dp_status,
   output logic                    busy,
   output pcpfl_pkg::ctl_cmd_type  ctl_cmd
);

   typedef enum logic [1:0] {
      IDLE,
      EVAL,
      EXEC,
      LINK
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               state_in = EVAL;
            end
         end
         EVAL: state_in = EXEC;
         EXEC: state_in = dp_status.alloc_hit ? LINK : IDLE;
         LINK: state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   // state and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != IDLE);
      end
   end

   // datapath commands
   always_comb begin
      ctl_cmd.load = (state_ff == IDLE) && start;
      ctl_cmd.eval = (state_ff == EVAL);
      ctl_cmd.exec = (state_ff == EXEC);
      ctl_cmd.link = (state_ff == LINK);
   end

   assign busy = busy_ff;

endmodule

// ===== design/pcpfl_dpath.sv =====
// datapath: config registers, list heads, link memory and result word
// depends on pcpfl_pkg and pcpfl_ram
module pcpfl_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pcpfl_pkg::ctl_cmd_type                 ctl_cmd,
   output pcpfl_pkg::dp_status_type               dp_status,
   input  logic                                   req_command,
   input  logic [pcpfl_pkg::CPU_IN_W-1:0]         req_cpu_index,
   input  logic [pcpfl_pkg::ADDR_W-1:0]           req_page_addr,
   input  logic                                   csr_write,
   input  logic                                   csr_index,
   input  logic [pcpfl_pkg::ADDR_W-1:0]           csr_data,
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_status,
   output logic [pcpfl_pkg::ADDR_W-1:0]           rsp_granted_addr
);

   localparam int CPU_W   = pcpfl_pkg::CPU_W;
   localparam int IDX_W   = pcpfl_pkg::IDX_W;
   localparam int ADDR_W  = pcpfl_pkg::ADDR_W;
   localparam int FIRST_W = pcpfl_pkg::FIRST_W;
   localparam int DIFF_W  = pcpfl_pkg::DIFF_W;
   localparam int PSHIFT  = pcpfl_pkg::PAGE_SHIFT;

   // config registers
   logic [ADDR_W-1:0]  base_ff;
   logic [ADDR_W-1:0]  top_ff;
   logic [FIRST_W-1:0] first_ff;
   logic [ADDR_W:0]    base_round;

   // request word
   logic               cmd_ff;
   logic [CPU_W-1:0]   cpu_ff;
   logic [ADDR_W-1:0]  addr_ff;

   // evaluation results
   logic               bad_ff;
   logic [IDX_W-1:0]   rel_ff;
   logic [CPU_W-1:0]   sel_ff;
   logic               found_ff;
   logic [IDX_W-1:0]   idx_ff;

   // list heads
   logic [IDX_W-1:0]   head_ff [pcpfl_pkg::CPU_COUNT];
   logic [pcpfl_pkg::CPU_COUNT-1:0] head_valid_ff;

   // result word
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;

   // combinational helpers
   logic               misaligned;
   logic               below_base;
   logic               above_top;
   logic [DIFF_W-1:0]  diff;
   logic               beyond_table;
   logic [CPU_W-1:0]   pick;
   logic               any_valid;
   logic [CPU_W-1:0]   sel_in;
   logic               is_alloc;
   logic [IDX_W-1:0]   sel_head;
   logic               sel_valid;
   logic [FIRST_W-1:0] page_sum;
   logic [ADDR_W-1:0]  granted_in;
   logic               mem_wr;
   logic               mem_rd;
   logic [IDX_W:0]     link_rd;

   assign base_round = {1'b0, csr_data} + (ADDR_W+1)'((1 << PSHIFT) - 1);
   assign is_alloc   = (cmd_ff == pcpfl_pkg::CMD_ALLOC);

   // free address check
   always_comb begin
      misaligned   = |addr_ff[PSHIFT-1:0];
      below_base   = addr_ff < base_ff;
      above_top    = addr_ff >= top_ff;
      diff         = DIFF_W'(addr_ff[ADDR_W-1:PSHIFT]) - DIFF_W'(first_ff);
      beyond_table = diff >= DIFF_W'(pcpfl_pkg::PAGE_COUNT);
   end

   // list selection: own list first, else lowest non-empty list
   always_comb begin
      pick = '0;
      for (int i = pcpfl_pkg::CPU_COUNT - 1; i >= 0; i--) begin
         if (head_valid_ff[i]) begin
            pick = CPU_W'(i);
         end
      end
      any_valid = |head_valid_ff;
      if (!is_alloc || head_valid_ff[cpu_ff]) begin
         sel_in = cpu_ff;
      end else begin
         sel_in = pick;
      end
   end

   assign sel_head  = head_ff[sel_ff];
   assign sel_valid = head_valid_ff[sel_ff];

   // granted address from the current base
   assign page_sum   = first_ff + FIRST_W'(idx_ff);
   assign granted_in = {page_sum[ADDR_W-PSHIFT-1:0], {PSHIFT{1'b0}}};

   // link memory access
   assign mem_wr = ctl_cmd.exec && !is_alloc && !bad_ff;
   assign mem_rd = ctl_cmd.exec && is_alloc && found_ff;

   pcpfl_ram #(
      .WIDTH(pcpfl_pkg::LINK_W),
      .DEPTH(pcpfl_pkg::PAGE_COUNT)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (mem_wr),
      .wr_addr(rel_ff),
      .wr_data({sel_valid, sel_head}),
      .rd_en  (mem_rd),
      .rd_addr(sel_head),
      .rd_data(link_rd)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         top_ff   <= '0;
         first_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            pcpfl_pkg::CSR_BASE_ADDR: begin
               base_ff  <= csr_data;
               first_ff <= base_round[ADDR_W:PSHIFT];
            end
            pcpfl_pkg::CSR_TOP_ADDR: top_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // request word and evaluation registers
   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         cmd_ff  <= req_command;
         cpu_ff  <= pcpfl_pkg::cpu_wrap(req_cpu_index);
         addr_ff <= req_page_addr;
      end
      if (ctl_cmd.eval) begin
         bad_ff   <= misaligned || below_base || above_top || beyond_table;
         rel_ff   <= diff[IDX_W-1:0];
         sel_ff   <= sel_in;
         found_ff <= any_valid;
      end
      if (mem_rd) begin
         idx_ff <= sel_head;
      end
   end

   // list heads: push on free, advance on pop
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
      end else if (mem_wr) begin
         head_valid_ff[sel_ff] <= 1'b1;
      end else if (ctl_cmd.link) begin
         head_valid_ff[sel_ff] <= link_rd[IDX_W];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         head_ff[sel_ff] <= rel_ff;
      end else if (ctl_cmd.link) begin
         head_ff[sel_ff] <= link_rd[IDX_W] ? link_rd[IDX_W-1:0] : '0;
      end
   end

   // result word, shown for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (ctl_cmd.exec && !(is_alloc && found_ff)) || ctl_cmd.link;
      end
      if (ctl_cmd.exec) begin
         rsp_addr_ff <= '0;
         if (is_alloc) begin
            rsp_status_ff <= pcpfl_pkg::ST_NO_PAGE;
         end else if (bad_ff) begin
            rsp_status_ff <= pcpfl_pkg::ST_BAD_FREE;
         end else begin
            rsp_status_ff <= pcpfl_pkg::ST_OK;
         end
      end else if (ctl_cmd.link) begin
         rsp_status_ff <= pcpfl_pkg::ST_OK;
         rsp_addr_ff   <= granted_in;
      end
   end

   assign dp_status.alloc_hit = is_alloc && found_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_addr    = rsp_addr_ff;

endmodule

// ===== design/per_cpu_page_free_list_allocator.sv =====
// per-cpu page free list allocator with stealing, top level
// depends on pcpfl_pkg, pcpfl_ctrl, pcpfl_dpath and the assertion macro header
//
// usage:
//   a request word (command, cpu index, page address) is taken at a clock edge
//   with start high and busy low. free pushes a checked, page-aligned address
//   onto the cpu's list; allocate pops the cpu's own list, else steals the
//   head of the lowest-numbered non-empty list.
//   each request gives exactly one result word, shown for one cycle with
//   rsp_valid high; the receiver has no way to hold it off.
//   a free or a failed allocate passes the address check in EVAL and then EXEC;
//   a granted allocate adds LINK, for the registered read of the link memory.
//   busy stays high until the result word is registered, so one request
//   runs at a time.
//   base_addr and top_addr are written through csr_write, csr_index, csr_data;
//   the user must do so with the block idle; the block does not enforce it.
//   reset empties every list and clears the registers; the link memory is
//   left as is, since a link is always written before it is followed.
`include "per_cpu_page_free_list_allocator_defines.svh"
module per_cpu_page_free_list_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_command,
   input  logic [pcpfl_pkg::CPU_IN_W-1:0] req_cpu_index,
   input  logic [pcpfl_pkg::ADDR_W-1:0]   req_page_addr,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [pcpfl_pkg::ADDR_W-1:0]   rsp_granted_addr,
   input  logic                           csr_write,
   input  logic                           csr_index,
   input  logic [pcpfl_pkg::ADDR_W-1:0]   csr_data
);

   pcpfl_pkg::ctl_cmd_type   ctl_cmd;
   pcpfl_pkg::dp_status_type dp_status;
   logic                     accept;

   assign accept = start && !busy;

   // request sequencer
   pcpfl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dp_status(dp_status),
      .busy     (busy),
      .ctl_cmd  (ctl_cmd)
   );

   // lists, link memory and result word
   pcpfl_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl_cmd         (ctl_cmd),
      .dp_status       (dp_status),
      .req_command     (req_command),
      .req_cpu_index   (req_cpu_index),
      .req_page_addr   (req_page_addr),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_granted_addr(rsp_granted_addr)
   );

   // checks
   `PCPFL_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `PCPFL_ASSERT_NEXT(a_single_word, clock, reset, rsp_valid, !rsp_valid)
   `PCPFL_ASSERT_SAME(a_word_after_busy, clock, reset, rsp_valid, $past(busy))
   `PCPFL_ASSERT_SAME(a_no_addr_on_fail, clock, reset,
      rsp_valid && (rsp_status != pcpfl_pkg::ST_OK), rsp_granted_addr == '0)

endmodule

// ===== tb/tb_per_cpu_page_free_list_allocator.sv =====
`timescale 1ns / 1ps
// testbench of the per-cpu page free list allocator: directed and random request words,
// each result word checked against a shadow copy of the per-cpu free lists
// depends on pcpfl_pkg and per_cpu_page_free_list_allocator
module tb_per_cpu_page_free_list_allocator;
   import pcpfl_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
   localparam logic [ADDR_W:0] PAGE_ROUND = (ADDR_W+1)'((1 << PAGE_SHIFT) - 1);

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] granted;
   } grant_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_command = CMD_FREE;
   logic [CPU_IN_W-1:0] req_cpu_index = '0;
   logic [ADDR_W-1:0]   req_page_addr = '0;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [ADDR_W-1:0]   rsp_granted_addr;
   logic                csr_write = 1'b0;
   logic                csr_index = CSR_BASE_ADDR;
   logic [ADDR_W-1:0]   csr_data = '0;

   // shadow of the block's registers and free lists
   logic [ADDR_W-1:0] shadow_base = '0;
   logic [ADDR_W-1:0] shadow_top = '0;
   logic [IDX_W-1:0]  shadow_head [CPU_COUNT];
   bit                shadow_head_ok [CPU_COUNT];
   logic [IDX_W-1:0]  shadow_link [PAGE_COUNT];
   bit                shadow_link_ok [PAGE_COUNT];
   // pages believed to sit on some list, only used to steer frees
   bit                page_listed [PAGE_COUNT];

   grant_word_type pending_grants [$];
   int             mismatch_count = 0;
   int             stall_cycles = 0;

   per_cpu_page_free_list_allocator i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_cpu_index    (req_cpu_index),
      .req_page_addr    (req_page_addr),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_granted_addr (rsp_granted_addr),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #6 clock = ~clock;

   // page number of base rounded up to a page boundary
   function automatic logic [FIRST_W-1:0] first_page();
      logic [ADDR_W:0] rounded;
      rounded = {1'b0, shadow_base} + PAGE_ROUND;
      return rounded[ADDR_W:PAGE_SHIFT];
   endfunction

   function automatic logic [ADDR_W-1:0] page_address(input logic [FIRST_W-1:0] page);
      logic [FIRST_W+PAGE_SHIFT-1:0] wide;
      wide = {page, {PAGE_SHIFT{1'b0}}};
      return wide[ADDR_W-1:0];
   endfunction

   function automatic bit pop_page(input int cpu, output logic [IDX_W-1:0] idx);
      if (!shadow_head_ok[cpu]) begin
         return 1'b0;
      end
      idx = shadow_head[cpu];
      if (shadow_link_ok[idx]) begin
         shadow_head[cpu] = shadow_link[idx];
      end else begin
         shadow_head_ok[cpu] = 1'b0;
         shadow_head[cpu] = '0;
      end
      return 1'b1;
   endfunction

   // result word of one request, updating the shadow lists
   function automatic grant_word_type serve_request(input logic cmd,
                                                    input logic [CPU_IN_W-1:0] cpu_in,
                                                    input logic [ADDR_W-1:0] addr);
      grant_word_type     word;
      logic [FIRST_W-1:0] first;
      logic [FIRST_W-1:0] rel;
      logic [IDX_W-1:0]   idx;
      int                 cpu;
      bit                 got;
      first = first_page();
      cpu = int'(cpu_in) % CPU_COUNT;
      word.status = ST_OK;
      word.granted = '0;
      idx = '0;
      if (cmd == CMD_FREE) begin
         rel = FIRST_W'(addr[ADDR_W-1:PAGE_SHIFT]) - first;
         if (addr[PAGE_SHIFT-1:0] != '0 || addr < shadow_base || addr >= shadow_top
             || rel >= FIRST_W'(PAGE_COUNT)) begin
            word.status = ST_BAD_FREE;
         end else begin
            idx = rel[IDX_W-1:0];
            shadow_link[idx] = shadow_head[cpu];
            shadow_link_ok[idx] = shadow_head_ok[cpu];
            shadow_head[cpu] = idx;
            shadow_head_ok[cpu] = 1'b1;
            page_listed[idx] = 1'b1;
         end
      end else begin
         // own list first, then steal in ascending cpu order
         got = pop_page(cpu, idx);
         for (int c = 0; c < CPU_COUNT && !got; c++) begin
            if (c != cpu) begin
               got = pop_page(c, idx);
            end
         end
         if (got) begin
            word.granted = page_address(first + FIRST_W'(idx));
            page_listed[idx] = 1'b0;
         end else begin
            word.status = ST_NO_PAGE;
         end
      end
      return word;
   endfunction

   // drive one request word and hold it until the block takes it
   task automatic send_word(input logic cmd, input logic [CPU_IN_W-1:0] cpu,
                            input logic [ADDR_W-1:0] addr);
      start <= 1'b1;
      req_command <= cmd;
      req_cpu_index <= cpu;
      req_page_addr <= addr;
      do @(posedge clock); while (busy);
      pending_grants.push_back(serve_request(cmd, cpu, addr));
      @(negedge clock);
   endtask

   task automatic pause_words(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // wait until every result word is back and the block has settled
   task automatic drain_results();
      start <= 1'b0;
      while (pending_grants.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_range(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] top);
      csr_write <= 1'b1;
      csr_index <= CSR_BASE_ADDR;
      csr_data <= base;
      @(negedge clock);
      csr_index <= CSR_TOP_ADDR;
      csr_data <= top;
      @(negedge clock);
      csr_write <= 1'b0;
      shadow_base = base;
      shadow_top = top;
   endtask

   // mostly pages off the lists, drawn equally from the bottom and the top of the table
   function automatic logic [IDX_W-1:0] pick_page_index();
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int tries = 0; tries < 8; tries++) begin
         idx = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 39))
                                    : IDX_W'($urandom_range(PAGE_COUNT - 40, PAGE_COUNT - 1));
         if (!page_listed[idx]) begin
            break;
         end
      end
      return idx;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_free_address();
      int                 kind;
      logic [FIRST_W-1:0] first;
      logic [ADDR_W-1:0]  addr;
      first = first_page();
      kind = $urandom_range(0, 99);
      addr = page_address(first + FIRST_W'(pick_page_index()));
      if (kind >= 97) begin
         addr = ADDR_W'({$urandom, $urandom});
      end else if (kind >= 94) begin
         // aligned but past the link table
         addr = page_address(first + FIRST_W'(PAGE_COUNT) + FIRST_W'($urandom_range(0, 255)));
      end else if (kind >= 91) begin
         // first page at or above top
         addr = {shadow_top[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
         if (addr < shadow_top) begin
            addr = addr + (ADDR_W'(1) << PAGE_SHIFT);
         end
      end else if (kind >= 88) begin
         if (shadow_base != '0) begin
            addr = ADDR_W'({$urandom, $urandom}) % shadow_base;
            if ($urandom_range(0, 1) == 0) begin
               addr[PAGE_SHIFT-1:0] = '0;
            end
         end
      end else if (kind >= 85) begin
         addr[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
      end
      return addr;
   endfunction

   // chunks of 32 words with their own alloc share, hot cpu and gap setting
   task automatic random_traffic(input int count, input bit with_gaps);
      int                  alloc_pct;
      int                  hot_cpu;
      bit                  gaps_on;
      logic                cmd;
      logic [CPU_IN_W-1:0] cpu;
      logic [ADDR_W-1:0]   addr;
      alloc_pct = 50;
      hot_cpu = 0;
      gaps_on = 1'b0;
      for (int n = 0; n < count; n++) begin
         if (n % 32 == 0) begin
            alloc_pct = 25 * $urandom_range(1, 3);
            hot_cpu = $urandom_range(0, CPU_COUNT - 1);
            gaps_on = with_gaps && ($urandom_range(0, 2) != 0);
         end
         cmd = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
         cpu = ($urandom_range(0, 9) < 3) ? CPU_IN_W'(hot_cpu)
                                          : CPU_IN_W'($urandom_range(0, 7));
         addr = (cmd == CMD_FREE) ? pick_free_address() : ADDR_W'({$urandom, $urandom});
         if (gaps_on && $urandom_range(0, 3) == 0) begin
            pause_words($urandom_range(1, 11));
         end
         send_word(cmd, cpu, addr);
      end
      drain_results();
   endtask

   // registers still at reset: empty range, so every free fails
   task automatic test_empty_after_reset();
      send_word(CMD_FREE, 3'd0, 40'h0);
      send_word(CMD_ALLOC, 3'd0, 40'h0);
      drain_results();
   endtask

   // misaligned, below base, at top, and both ends of an unaligned base range
   task automatic test_address_checks();
      set_range(40'h00_0000_1234, 40'h00_0010_2000);
      send_word(CMD_FREE, 3'd1, 40'h00_0000_2001);
      send_word(CMD_FREE, 3'd1, 40'h00_0000_1000);
      send_word(CMD_FREE, 3'd1, 40'h00_0010_2000);
      send_word(CMD_FREE, 3'd0, 40'h00_0010_1000);
      send_word(CMD_FREE, 3'd7, 40'h00_0000_2000);
      send_word(CMD_ALLOC, 3'd7, ADDR_ONES);
      send_word(CMD_ALLOC, 3'd7, 40'h0);
      send_word(CMD_ALLOC, 3'd3, 40'h0);
      drain_results();
   endtask

   // full address range: last table entry, page past the table, all-ones address
   task automatic test_table_edge();
      set_range(40'h0, ADDR_ONES);
      send_word(CMD_FREE, 3'd3, 40'h00_07FF_F000);
      send_word(CMD_FREE, 3'd3, 40'h00_0800_0000);
      send_word(CMD_FREE, 3'd6, ADDR_ONES);
      send_word(CMD_FREE, 3'd3, 40'h0);
      send_word(CMD_ALLOC, 3'd3, 40'h0);
      send_word(CMD_ALLOC, 3'd5, 40'h0);
      drain_results();
   endtask

   // steal order, a page freed onto two lists, and base moved under listed pages
   task automatic test_steal_and_double_free();
      set_range(40'h00_0000_5000, 40'h00_0010_0000);
      send_word(CMD_FREE, 3'd6, 40'h00_0000_6000);
      send_word(CMD_FREE, 3'd4, 40'h00_0000_7000);
      send_word(CMD_FREE, 3'd1, 40'h00_0000_8000);
      send_word(CMD_FREE, 3'd2, 40'h00_0000_8000);
      send_word(CMD_ALLOC, 3'd0, 40'h0);
      send_word(CMD_ALLOC, 3'd0, 40'h0);
      send_word(CMD_ALLOC, 3'd0, 40'h0);
      drain_results();
      // rounding the base up carries out of the address width
      set_range(40'hFF_FFFF_F001, ADDR_ONES);
      send_word(CMD_FREE, 3'd0, 40'h00_0000_3000);
      send_word(CMD_ALLOC, 3'd0, 40'h0);
      send_word(CMD_ALLOC, 3'd0, 40'h0);
      drain_results();
   endtask

   task automatic test_random_low_range();
      logic [ADDR_W-1:0] base;
      base = ADDR_W'($urandom);
      set_range(base, '0);
      set_range(base, page_address(first_page() + FIRST_W'(PAGE_COUNT)));
      random_traffic(250, 1'b1);
   endtask

   task automatic test_random_high_range();
      set_range(40'hFF_F000_0000 | ADDR_W'($urandom_range(0, 24'hFF_FFFF)), ADDR_ONES);
      random_traffic(200, 1'b1);
   endtask

   // top at or below base: frees all rejected, lists drain
   task automatic test_random_inverted_range();
      logic [ADDR_W-1:0] base;
      base = ADDR_W'({$urandom, $urandom});
      set_range(base, base - ADDR_W'($urandom_range(0, 1 << 20)));
      random_traffic(30, 1'b1);
      set_range(ADDR_ONES, '0);
      random_traffic(30, 1'b1);
   endtask

   task automatic test_random_full_range();
      set_range('0, ADDR_ONES);
      random_traffic(150, 1'b1);
      random_traffic(140, 1'b0);
   endtask

   // compare each result word with the oldest prediction
   always @(posedge clock) begin : check_words
      grant_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result word: status %0d addr %h",
                        rsp_status, rsp_granted_addr);
            end
         end else begin
            want = pending_grants.pop_front();
            if (rsp_status !== want.status || rsp_granted_addr !== want.granted) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result word mismatch: expected status %0d addr %h, got %0d %h",
                           want.status, want.granted, rsp_status, rsp_granted_addr);
               end
            end
         end
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("per_cpu_page_free_list_allocator regression: fail");
         $finish;
      end
   end

   initial begin
      for (int c = 0; c < CPU_COUNT; c++) begin
         shadow_head[c] = '0;
      end
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_empty_after_reset();
      test_address_checks();
      test_table_edge();
      test_steal_and_double_free();
      test_random_low_range();
      test_random_high_range();
      test_random_inverted_range();
      test_random_full_range();
      drain_results();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("per_cpu_page_free_list_allocator regression: pass");
      end else begin
         $display("per_cpu_page_free_list_allocator regression: fail");
      end
      $finish;
   end

endmodule
